// File: rtl/core/pf_pkg.sv
// shared types, constants and square arithmetic for the playfair encryptor
`default_nettype none

package pf_pkg;

    localparam int ALPHA  = 26;
    localparam int CELLS  = 25;
    localparam int SIDE   = 5;
    localparam int LW     = 5;
    localparam int DATA_W = 8;
    localparam int REQ_W  = 3;

    typedef logic [LW-1:0]    t_letter;
    typedef logic [4:0]       t_cell;
    typedef logic [2:0]       t_rc;
    typedef logic [REQ_W-1:0] t_req;

    localparam t_letter LET_I = 5'd8;
    localparam t_letter LET_J = 5'd9;
    localparam t_letter LET_X = 5'd23;

    localparam t_req REQ_NEW_KEY = 3'd0;
    localparam t_req REQ_KEY     = 3'd1;
    localparam t_req REQ_FINISH  = 3'd2;
    localparam t_req REQ_PLAIN   = 3'd3;
    localparam t_req REQ_FLUSH   = 3'd4;

    function automatic t_letter fold_j(t_letter c);
        return (c == LET_J) ? LET_I : c;
    endfunction

    function automatic t_rc cell_row(t_cell p);
        t_rc r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic t_rc cell_col(t_cell p);
        t_cell base;
        base = t_cell'(cell_row(p)) * t_cell'(SIDE);
        return t_rc'(p - base);
    endfunction

    function automatic t_rc wrap_inc(t_rc v);
        return (v == t_rc'(SIDE - 1)) ? t_rc'(0) : t_rc'(v + 3'd1);
    endfunction

    function automatic t_cell cell_index(t_rc r, t_rc c);
        return t_cell'(r) * t_cell'(SIDE) + t_cell'(c);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pf_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module pf_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/pf_out_buf.sv
// two-entry result buffer that hands out one digraph on the master stream
`default_nettype none

module pf_out_buf (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire pf_pkg::t_letter       i_first,
    input  wire pf_pkg::t_letter       i_second,
    output logic                       o_empty,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [pf_pkg::DATA_W-1:0]  o_m_tdata,   // [4:0] cipher_letter, rest zero
    output logic                       o_m_tlast    // last_of_pair
);

    import pf_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_letter    r_first;
    t_letter    r_second;
    logic       pop;

    assign pop        = o_m_tvalid && i_m_tready;
    assign o_empty    = (r_cnt == 2'd0);
    assign o_m_tvalid = !o_empty;
    assign o_m_tdata  = DATA_W'((r_cnt == 2'd2) ? r_first : r_second);
    assign o_m_tlast  = (r_cnt == 2'd1);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push) begin
            n_cnt = 2'd2;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_first  <= i_first;
            r_second <= i_second;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/playfair_cipher_encryptor_unit.sv
// playfair encryptor: key square build, digraph pairing and encryption
//
// slave stream: tuser carries the request kind (new key, key letter, finish
// key, plaintext letter, flush), tdata[4:0] the letter code. master stream:
// tdata[4:0] is a ciphertext letter, tlast marks the second letter of a pair.
// a request is taken only while the control sequencer is idle.
// new key and key letter requests leave the sequencer idle; a finish request
// walks the alphabet one letter per cycle through the write ports of the
// square and position memories.
// a plaintext letter that closes a pair, or a flush with a pending letter,
// runs two position lookups then two square lookups, in turn on the single
// read port of each memory. the first cipher letter is valid once the pair
// is registered in the output buffer, the second once the first is taken.
// both result letters wait in an output buffer, so the next request is taken
// while the receiver stalls; a new pair waits in its last step until the
// buffer has drained.
// reset empties the buffer and clears the letter set, fill count and the
// pending letter; the memories keep their contents until rewritten.
`default_nettype none

module playfair_cipher_encryptor_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [pf_pkg::DATA_W-1:0] i_s_tdata, // [4:0] letter, rest zero
    input  wire logic [pf_pkg::REQ_W-1:0]  i_s_tuser, // [2:0] req_type
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [pf_pkg::DATA_W-1:0]  o_m_tdata,     // [4:0] cipher_letter, rest zero
    output logic                       o_m_tlast      // last_of_pair
);

    import pf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_PA   = 3'd2;
    localparam logic [2:0] S_PB   = 3'd3;
    localparam logic [2:0] S_SA   = 3'd4;
    localparam logic [2:0] S_SB   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [ALPHA-1:0] r_used, n_used;
    t_cell            r_fill, n_fill;
    t_letter          r_k, n_k;
    t_letter          r_pend, n_pend;
    logic             r_pv, n_pv;
    t_letter          r_b, n_b;
    t_cell            r_pa, n_pa;
    t_cell            r_ib, n_ib;
    t_letter          r_oa, n_oa;
    t_letter          r_ob, n_ob;

    logic    accept;
    t_req    req;
    t_letter raw;
    t_letter c;
    logic    in_ok;
    t_letter enc_b;

    t_letter pl_letter;
    logic    pl_req;
    logic    pl_do;

    t_letter pos_raddr;
    t_letter pos_rdata;
    t_cell   sq_raddr;
    t_letter sq_rdata;

    t_cell pb;
    t_rc   ra, ca, rb, cb;
    t_cell ia, ib;

    logic buf_empty;
    logic buf_push;
    t_letter buf_first, buf_second;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign req        = i_s_tuser;
    assign raw        = i_s_tdata[LW-1:0];
    assign in_ok      = (raw < t_letter'(ALPHA));
    assign c          = fold_j(raw);
    assign enc_b      = ((req == REQ_FLUSH) || (r_pend == c)) ? LET_X : c;

    // key placement, from a key letter request or the finishing walk
    assign pl_letter = (r_state == S_FILL) ? r_k : c;
    assign pl_req    = ((r_state == S_FILL) && (r_k != LET_J))
                    || (accept && (req == REQ_KEY) && in_ok);
    assign pl_do     = pl_req && (r_fill < t_cell'(CELLS)) && !r_used[pl_letter];

    // lookup address muxes
    assign pos_raddr = (r_state == S_IDLE) ? r_pend : r_b;
    assign sq_raddr  = (r_state == S_SA) ? r_ib : ia;

    assign pb = (pos_rdata >= t_letter'(CELLS)) ? t_cell'(0) : t_cell'(pos_rdata);
    assign ra = cell_row(r_pa);
    assign ca = cell_col(r_pa);
    assign rb = cell_row(pb);
    assign cb = cell_col(pb);

    always_comb begin
        if (ca == cb) begin
            ia = cell_index(wrap_inc(ra), ca);
            ib = cell_index(wrap_inc(rb), cb);
        end else if (ra == rb) begin
            ia = cell_index(ra, wrap_inc(ca));
            ib = cell_index(rb, wrap_inc(cb));
        end else begin
            ia = cell_index(ra, cb);
            ib = cell_index(rb, ca);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_fill     = r_fill;
        n_k        = r_k;
        n_pend     = r_pend;
        n_pv       = r_pv;
        n_b        = r_b;
        n_pa       = r_pa;
        n_ib       = r_ib;
        n_oa       = r_oa;
        n_ob       = r_ob;
        buf_push   = 1'b0;
        buf_first  = r_oa;
        buf_second = sq_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (req)
                        REQ_NEW_KEY: begin
                            n_used = '0;
                            n_fill = '0;
                            n_pv   = 1'b0;
                        end
                        REQ_FINISH: begin
                            n_k     = '0;
                            n_state = S_FILL;
                        end
                        REQ_PLAIN: begin
                            if (in_ok) begin
                                if (!r_pv) begin
                                    n_pend = c;
                                    n_pv   = 1'b1;
                                end else begin
                                    // doubled letter stays pending
                                    n_pv    = (r_pend == c);
                                    n_b     = enc_b;
                                    n_state = S_PA;
                                end
                            end
                        end
                        REQ_FLUSH: begin
                            if (r_pv) begin
                                n_pv    = 1'b0;
                                n_b     = enc_b;
                                n_state = S_PA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                n_k = r_k + 5'd1;
                if (r_k == t_letter'(ALPHA - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_PA: begin
                n_pa    = pb;
                n_state = S_PB;
            end
            S_PB: begin
                n_ib    = ib;
                n_state = S_SA;
            end
            S_SA: begin
                n_oa    = sq_rdata;
                n_state = S_SB;
            end
            S_SB: begin
                if (buf_empty) begin
                    buf_push = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_ob    = sq_rdata;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                buf_second = r_ob;
                if (buf_empty) begin
                    buf_push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (pl_do) begin
            n_used[pl_letter] = 1'b1;
            n_fill            = r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_fill  <= '0;
            r_k     <= '0;
            r_pend  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_fill  <= n_fill;
            r_k     <= n_k;
            r_pend  <= n_pend;
            r_pv    <= n_pv;
        end
        r_b  <= n_b;
        r_pa <= n_pa;
        r_ib <= n_ib;
        r_oa <= n_oa;
        r_ob <= n_ob;
    end

    pf_ram #(
        .WIDTH (LW),
        .DEPTH (CELLS)
    ) u_square (
        .i_clk   (i_clk),
        .i_we    (pl_do),
        .i_waddr (r_fill),
        .i_wdata (pl_letter),
        .i_raddr (sq_raddr),
        .o_rdata (sq_rdata)
    );

    pf_ram #(
        .WIDTH (LW),
        .DEPTH (ALPHA)
    ) u_position (
        .i_clk   (i_clk),
        .i_we    (pl_do),
        .i_waddr (pl_letter),
        .i_wdata (r_fill),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    pf_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (buf_push),
        .i_first    (buf_first),
        .i_second   (buf_second),
        .o_empty    (buf_empty),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
